// ===== rtl/cfr_pkg.sv =====
// Shared constants, types and control structures of the command frame responder.
package cfr_pkg;

    localparam int unsigned CFR_FRAME_MAX = 64;
    localparam int unsigned POS_W         = 6;
    localparam int unsigned IDX_W         = 4;
    localparam int unsigned NUM_PARAMS    = 4;
    localparam int unsigned REG_IDX_W     = 2;
    localparam int unsigned ADDR_W        = REG_IDX_W + 2;
    localparam int unsigned DATA_W        = 32;

    typedef logic [DATA_W-1:0] param_word_t;
    typedef logic [REG_IDX_W-1:0] reg_idx_t;

    localparam reg_idx_t REG_PARAM_ONE   = 2'd0;
    localparam reg_idx_t REG_PARAM_TWO   = 2'd1;
    localparam reg_idx_t REG_PARAM_THREE = 2'd2;
    localparam reg_idx_t REG_PARAM_FOUR  = 2'd3;

    localparam param_word_t PARAM_ONE_RESET   = 32'h0000_0005;
    localparam param_word_t PARAM_OTHER_RESET = 32'h0000_00FF;

    localparam logic [15:0] ID_PARAM_ONE   = 16'd1;
    localparam logic [15:0] ID_PARAM_TWO   = 16'd2;
    localparam logic [15:0] ID_PARAM_THREE = 16'd3;
    localparam logic [15:0] ID_PARAM_FOUR  = 16'd4;

    localparam logic [7:0] HDR_SYNC        = 8'hAA;
    localparam logic [7:0] HDR_ADDR        = 8'hFF;
    localparam logic [7:0] FN_PARAM_READ   = 8'hE1;
    localparam logic [7:0] FN_PARAM_REPLY  = 8'hE2;
    localparam logic [7:0] FN_ACK          = 8'hE0;
    localparam logic [7:0] ACK_FN_FIELD    = 8'h00;
    localparam logic [7:0] LEN_PARAM_REPLY = 8'h06;
    localparam logic [7:0] LEN_ACK         = 8'h03;

    localparam logic [POS_W-1:0] POS_FUNC   = 6'd2;
    localparam logic [POS_W-1:0] POS_ID_LO  = 6'd4;
    localparam logic [POS_W-1:0] POS_ID_HI  = 6'd5;
    localparam logic [POS_W-1:0] POS_STAT_A = 6'd15;
    localparam logic [POS_W-1:0] POS_STAT_B = 6'd16;
    localparam logic [POS_W-1:0] POS_LIMIT  = '1;

    // Number of bytes ahead of the two checksum bytes in each reply.
    localparam logic [IDX_W-1:0] READ_DATA_LEN = 4'd10;
    localparam logic [IDX_W-1:0] ACK_DATA_LEN  = 4'd7;
    localparam logic [IDX_W-1:0] NONE_DATA_LEN = 4'd0;

    typedef enum logic [1:0] {
        SEL_DATA,
        SEL_SUM,
        SEL_ACC
    } byte_sel_t;

    typedef struct packed {
        logic             capture;
        logic             load;
        byte_sel_t        sel;
        logic [IDX_W-1:0] idx;
        logic             last;
        logic             clear;
    } dp_cmd_t;

    typedef struct packed {
        logic is_read;
        logic is_ack;
        logic out_free;
    } dp_status_t;

endpackage

// ===== rtl/cfr_stream_if.sv =====
// Receive and transmit byte stream interfaces of the command frame responder.
interface cfr_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       rx_last;

    modport source (output valid, output rx_byte, output rx_last, input ready);
    modport sink (input valid, input rx_byte, input rx_last, output ready);
endinterface

interface cfr_tx_if;
    logic       valid;
    logic       ready;
    logic [7:0] tx_byte;
    logic       tx_last;

    modport source (output valid, output tx_byte, output tx_last, input ready);
    modport sink (input valid, input tx_byte, input tx_last, output ready);
endinterface

// ===== rtl/cfr_regs.sv =====
// APB register file holding the four parameter values.
module cfr_regs
    import cfr_pkg::*;
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ADDR_W-1:0]              paddr,
    input  logic [DATA_W-1:0]              pwdata,
    output logic [DATA_W-1:0]              prdata,
    output logic                           pready,
    output logic [NUM_PARAMS-1:0][DATA_W-1:0] params
);

    logic [NUM_PARAMS-1:0][DATA_W-1:0] param_reg;
    logic [NUM_PARAMS-1:0][DATA_W-1:0] param_next;
    logic                              wr_en;
    reg_idx_t                          wr_idx;

    assign wr_en  = psel && penable && pwrite;
    assign wr_idx = paddr[ADDR_W-1:2];

    always_comb
    begin
        param_next = param_reg;
        if (wr_en)
        begin
            case (wr_idx)
                REG_PARAM_ONE:   param_next[REG_PARAM_ONE]   = pwdata;
                REG_PARAM_TWO:   param_next[REG_PARAM_TWO]   = pwdata;
                REG_PARAM_THREE: param_next[REG_PARAM_THREE] = pwdata;
                REG_PARAM_FOUR:  param_next[REG_PARAM_FOUR]  = pwdata;
                default:         param_next = param_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            param_reg[REG_PARAM_ONE]   <= PARAM_ONE_RESET;
            param_reg[REG_PARAM_TWO]   <= PARAM_OTHER_RESET;
            param_reg[REG_PARAM_THREE] <= PARAM_OTHER_RESET;
            param_reg[REG_PARAM_FOUR]  <= PARAM_OTHER_RESET;
        end
        else
        begin
            param_reg <= param_next;
        end
    end

    assign prdata = param_reg[wr_idx];
    assign pready = 1'b1;
    assign params = param_reg;

endmodule

// ===== rtl/cfr_ctrl.sv =====
// Controller: receive phase and reply sequencing.
module cfr_ctrl
    import cfr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       rx_valid,
    input  logic       rx_last,
    output logic       rx_ready,
    output dp_cmd_t    cmd,
    input  dp_status_t status
);

    typedef enum logic {
        ST_RECV,
        ST_EMIT
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic [IDX_W-1:0] data_len;

    assign rx_ready = (state_reg == ST_RECV);

    always_comb
    begin
        if (status.is_read)
        begin
            data_len = READ_DATA_LEN;
        end
        else if (status.is_ack)
        begin
            data_len = ACK_DATA_LEN;
        end
        else
        begin
            data_len = NONE_DATA_LEN;
        end
    end

    always_comb
    begin
        cmd         = '0;
        cmd.idx     = idx_reg;
        cmd.sel     = SEL_DATA;
        state_next  = state_reg;
        idx_next    = idx_reg;

        if (idx_reg < data_len)
        begin
            cmd.sel = SEL_DATA;
        end
        else if (idx_reg == data_len)
        begin
            cmd.sel = SEL_SUM;
        end
        else
        begin
            cmd.sel = SEL_ACC;
        end
        cmd.last = (cmd.sel == SEL_ACC);

        case (state_reg)
            ST_RECV:
            begin
                cmd.capture = rx_valid;
                if (rx_valid && rx_last)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                cmd.load  = status.out_free;
                cmd.clear = status.out_free && cmd.last;
                if (status.out_free)
                begin
                    if (cmd.last)
                    begin
                        state_next = ST_RECV;
                        idx_next   = '0;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_RECV;
                idx_next   = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_RECV;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

endmodule

// ===== rtl/cfr_datapath.sv =====
// Datapath: frame capture, reply byte selection, checksums and output register.
module cfr_datapath
    import cfr_pkg::*;
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [7:0]                        rx_byte,
    input  logic                              tx_ready,
    input  logic [NUM_PARAMS-1:0][DATA_W-1:0] params,
    input  dp_cmd_t                           cmd,
    output dp_status_t                        status,
    output logic                              tx_valid,
    output logic [7:0]                        tx_byte,
    output logic                              tx_last
);

    logic [POS_W-1:0] pos_reg,    pos_next;
    logic [7:0]       func_reg,   func_next;
    logic [7:0]       id_lo_reg,  id_lo_next;
    logic [7:0]       id_hi_reg,  id_hi_next;
    logic [7:0]       stat_a_reg, stat_a_next;
    logic [7:0]       stat_b_reg, stat_b_next;
    logic [7:0]       sum_reg,    sum_next;
    logic [7:0]       acc_reg,    acc_next;
    logic             tx_valid_reg, tx_valid_next;
    logic [7:0]       tx_byte_reg;
    logic             tx_last_reg;

    param_word_t      param_val;
    logic [7:0]       data_byte;
    logic [7:0]       out_byte;
    logic             is_read;
    logic             is_ack;

    assign is_read = (func_reg == FN_PARAM_READ);
    assign is_ack  = (func_reg == FN_ACK);

    always_comb
    begin
        case ({id_hi_reg, id_lo_reg})
            ID_PARAM_ONE:   param_val = params[REG_PARAM_ONE];
            ID_PARAM_TWO:   param_val = params[REG_PARAM_TWO];
            ID_PARAM_THREE: param_val = params[REG_PARAM_THREE];
            ID_PARAM_FOUR:  param_val = params[REG_PARAM_FOUR];
            default:        param_val = '0;
        endcase
    end

    // Reply body by byte index; the parameter value goes out least significant byte first.
    always_comb
    begin
        data_byte = '0;
        if (is_read)
        begin
            case (cmd.idx)
                4'd0:    data_byte = HDR_SYNC;
                4'd1:    data_byte = HDR_ADDR;
                4'd2:    data_byte = FN_PARAM_REPLY;
                4'd3:    data_byte = LEN_PARAM_REPLY;
                4'd4:    data_byte = id_lo_reg;
                4'd5:    data_byte = id_hi_reg;
                4'd6:    data_byte = param_val[7:0];
                4'd7:    data_byte = param_val[15:8];
                4'd8:    data_byte = param_val[23:16];
                4'd9:    data_byte = param_val[31:24];
                default: data_byte = '0;
            endcase
        end
        else
        begin
            case (cmd.idx)
                4'd0:    data_byte = HDR_SYNC;
                4'd1:    data_byte = HDR_ADDR;
                4'd2:    data_byte = ACK_FN_FIELD;
                4'd3:    data_byte = LEN_ACK;
                4'd4:    data_byte = func_reg;
                4'd5:    data_byte = stat_a_reg;
                4'd6:    data_byte = stat_b_reg;
                default: data_byte = '0;
            endcase
        end
    end

    always_comb
    begin
        case (cmd.sel)
            SEL_DATA: out_byte = data_byte;
            SEL_SUM:  out_byte = sum_reg;
            SEL_ACC:  out_byte = acc_reg;
            default:  out_byte = '0;
        endcase
    end

    always_comb
    begin
        pos_next    = pos_reg;
        func_next   = func_reg;
        id_lo_next  = id_lo_reg;
        id_hi_next  = id_hi_reg;
        stat_a_next = stat_a_reg;
        stat_b_next = stat_b_reg;
        sum_next    = sum_reg;
        acc_next    = acc_reg;

        if (cmd.capture)
        begin
            if (32'(pos_reg) < CFR_FRAME_MAX)
            begin
                case (pos_reg)
                    POS_FUNC:   func_next   = rx_byte;
                    POS_ID_LO:  id_lo_next  = rx_byte;
                    POS_ID_HI:  id_hi_next  = rx_byte;
                    POS_STAT_A: stat_a_next = rx_byte;
                    POS_STAT_B: stat_b_next = rx_byte;
                    default:    func_next   = func_reg;
                endcase
            end
            if (pos_reg != POS_LIMIT)
            begin
                pos_next = pos_reg + 1'b1;
            end
        end

        // The second checksum accumulates the running sum after each body byte.
        if (cmd.load && (cmd.sel == SEL_DATA))
        begin
            sum_next = sum_reg + data_byte;
            acc_next = acc_reg + sum_next;
        end

        if (cmd.clear)
        begin
            pos_next    = '0;
            func_next   = '0;
            id_lo_next  = '0;
            id_hi_next  = '0;
            stat_a_next = '0;
            stat_b_next = '0;
            sum_next    = '0;
            acc_next    = '0;
        end
    end

    always_comb
    begin
        tx_valid_next = tx_valid_reg;
        if (cmd.load)
        begin
            tx_valid_next = 1'b1;
        end
        else if (tx_ready)
        begin
            tx_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            func_reg     <= '0;
            id_lo_reg    <= '0;
            id_hi_reg    <= '0;
            stat_a_reg   <= '0;
            stat_b_reg   <= '0;
            sum_reg      <= '0;
            acc_reg      <= '0;
            tx_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg      <= pos_next;
            func_reg     <= func_next;
            id_lo_reg    <= id_lo_next;
            id_hi_reg    <= id_hi_next;
            stat_a_reg   <= stat_a_next;
            stat_b_reg   <= stat_b_next;
            sum_reg      <= sum_next;
            acc_reg      <= acc_next;
            tx_valid_reg <= tx_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            tx_byte_reg <= out_byte;
            tx_last_reg <= cmd.last;
        end
    end

    assign status.is_read  = is_read;
    assign status.is_ack   = is_ack;
    assign status.out_free = !tx_valid_reg || tx_ready;

    assign tx_valid = tx_valid_reg;
    assign tx_byte  = tx_byte_reg;
    assign tx_last  = tx_last_reg;

endmodule

// ===== rtl/command_frame_responder.sv =====
// Top level of the command frame responder.
//
// A command frame arrives on rx one word per cycle, rx_last on its final word.
// The block keeps the function code, the 16-bit parameter id and two status
// words, and after the final word streams a reply on tx, tx_last marking the
// closing cumulative checksum word.
// The final rx word moves the controller into its emit state, which loads
// the first reply word into the tx output register once that is free.
// Replies are 12 words for a parameter read, 9 for an acknowledge and 2
// otherwise, one word a cycle when tx is not stalled. Receive runs at one
// word per cycle; rx.ready is low while the reply is being loaded into the
// tx output register, which the reply sequencer fills one word at a time.
// The last reply word may still wait in the output register while the
// next frame is taken.
// A tx stall holds the output word and freezes the reply sequencer.
// Reset clears the frame capture and loads the parameter registers with
// their defaults (5, 255, 255, 255); the APB port writes them at offsets
// 0x0, 0x4, 0x8 and 0xC and reads them back with no wait states.
module command_frame_responder
    import cfr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    cfr_rx_if.sink            rx,
    cfr_tx_if.source          tx,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    logic [NUM_PARAMS-1:0][DATA_W-1:0] params;
    dp_cmd_t                           cmd;
    dp_status_t                        status;

    cfr_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .params  (params)
    );

    cfr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx_valid (rx.valid),
        .rx_last  (rx.rx_last),
        .rx_ready (rx.ready),
        .cmd      (cmd),
        .status   (status)
    );

    cfr_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx_byte  (rx.rx_byte),
        .tx_ready (tx.ready),
        .params   (params),
        .cmd      (cmd),
        .status   (status),
        .tx_valid (tx.valid),
        .tx_byte  (tx.tx_byte),
        .tx_last  (tx.tx_last)
    );

endmodule

// ===== rtl/cfr_checker.sv =====
// Port-level assertions for the command frame responder, with their bind.
module cfr_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       rx_valid,
    input logic       rx_ready,
    input logic       rx_last,
    input logic       tx_valid,
    input logic       tx_ready,
    input logic [7:0] tx_byte,
    input logic       tx_last
);

    // A stalled output word holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        tx_valid && !tx_ready |=> tx_valid && $stable(tx_byte) && $stable(tx_last))
    else $error("tx word changed while stalled");

    // The end of a frame stops reception for the reply.
    assert property (@(posedge clk) disable iff (!rst_n)
        rx_valid && rx_ready && rx_last |=> !rx_ready)
    else $error("rx still ready after the final frame word");

    // Reception stays closed while reply body words are still being shown.
    assert property (@(posedge clk) disable iff (!rst_n)
        tx_valid && !tx_last |-> !rx_ready)
    else $error("rx ready in the middle of a reply");

    // Once the closing checksum is loaded, reception is open again.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(tx_valid && tx_last) |-> rx_ready)
    else $error("rx not ready after the reply completed");

endmodule

bind command_frame_responder cfr_checker u_cfr_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .rx_valid (rx.valid),
    .rx_ready (rx.ready),
    .rx_last  (rx.rx_last),
    .tx_valid (tx.valid),
    .tx_ready (tx.ready),
    .tx_byte  (tx.tx_byte),
    .tx_last  (tx.tx_last)
);

// ===== sim/frame_reply_checker.sv =====
// Checker that predicts the reply words of the command frame responder and compares them.
module frame_reply_checker
    import cfr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    cfr_rx_if                 rx,
    cfr_tx_if                 tx,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    input  logic [DATA_W-1:0] prdata,
    input  logic              pready,
    output int                mismatch_count,
    output int                replies_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } reply_word_t;

    reply_word_t reply_q[$];

    param_word_t      param_shadow [NUM_PARAMS];
    logic [POS_W-1:0] frame_pos;
    logic [7:0]       fn_code;
    logic [7:0]       id_lo;
    logic [7:0]       id_hi;
    logic [7:0]       stat_a;
    logic [7:0]       stat_b;
    int               errors = 0;

    assign mismatch_count  = errors;
    assign replies_pending = reply_q.size();

    function automatic param_word_t param_for_id(input logic [15:0] id);
        case (id)
            ID_PARAM_ONE:   return param_shadow[REG_PARAM_ONE];
            ID_PARAM_TWO:   return param_shadow[REG_PARAM_TWO];
            ID_PARAM_THREE: return param_shadow[REG_PARAM_THREE];
            ID_PARAM_FOUR:  return param_shadow[REG_PARAM_FOUR];
            default:        return '0;
        endcase
    endfunction

    task automatic clear_capture();
        frame_pos = '0;
        fn_code   = '0;
        id_lo     = '0;
        id_hi     = '0;
        stat_a    = '0;
        stat_b    = '0;
    endtask

    // Takes one received word and queues the reply that the frame's last word causes.
    task automatic absorb_rx_word(input logic [7:0] b, input logic l);
        logic [7:0]  reply [12];
        int          n;
        logic [7:0]  sum;
        logic [7:0]  acc;
        param_word_t v;
        n   = 0;
        sum = '0;
        acc = '0;
        case (frame_pos)
            POS_FUNC:   fn_code = b;
            POS_ID_LO:  id_lo   = b;
            POS_ID_HI:  id_hi   = b;
            POS_STAT_A: stat_a  = b;
            POS_STAT_B: stat_b  = b;
            default: ;
        endcase
        if (frame_pos != POS_LIMIT)
            frame_pos = frame_pos + 1'b1;
        if (!l)
            return;
        if (fn_code == FN_PARAM_READ)
        begin
            v = param_for_id({id_hi, id_lo});
            reply[0] = HDR_SYNC;
            reply[1] = HDR_ADDR;
            reply[2] = FN_PARAM_REPLY;
            reply[3] = LEN_PARAM_REPLY;
            reply[4] = id_lo;
            reply[5] = id_hi;
            reply[6] = v[7:0];
            reply[7] = v[15:8];
            reply[8] = v[23:16];
            reply[9] = v[31:24];
            n = 10;
        end
        else if (fn_code == FN_ACK)
        begin
            reply[0] = HDR_SYNC;
            reply[1] = HDR_ADDR;
            reply[2] = ACK_FN_FIELD;
            reply[3] = LEN_ACK;
            reply[4] = fn_code;
            reply[5] = stat_a;
            reply[6] = stat_b;
            n = 7;
        end
        for (int i = 0; i < n; i++)
        begin
            sum = sum + reply[i];
            acc = acc + sum;
            reply_q.push_back('{data: reply[i], last: 1'b0});
        end
        reply_q.push_back('{data: sum, last: 1'b0});
        reply_q.push_back('{data: acc, last: 1'b1});
        clear_capture();
    endtask

    task automatic compare_tx_word(input logic [7:0] b, input logic l);
        reply_word_t want;
        if (reply_q.size() == 0)
        begin
            $error("tx word %h (last %b) with no reply word expected", b, l);
            errors++;
            return;
        end
        want = reply_q.pop_front();
        if (b !== want.data)
        begin
            $error("tx_byte mismatch: expected %h, actual %h", want.data, b);
            errors++;
        end
        if (l !== want.last)
        begin
            $error("tx_last mismatch: expected %b, actual %b", want.last, l);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_capture();
            reply_q.delete();
            param_shadow[REG_PARAM_ONE]   = PARAM_ONE_RESET;
            param_shadow[REG_PARAM_TWO]   = PARAM_OTHER_RESET;
            param_shadow[REG_PARAM_THREE] = PARAM_OTHER_RESET;
            param_shadow[REG_PARAM_FOUR]  = PARAM_OTHER_RESET;
        end
        else
        begin
            // The reply leaves only after the last word has been taken and registered, so the
            // order of these two within one edge does not matter.
            if (tx.valid && tx.ready)
                compare_tx_word(tx.tx_byte, tx.tx_last);
            if (rx.valid && rx.ready)
                absorb_rx_word(rx.rx_byte, rx.rx_last);
            if (psel && penable && pready)
            begin
                if (pwrite)
                    param_shadow[paddr[ADDR_W-1:2]] = pwdata;
                else if (prdata !== param_shadow[paddr[ADDR_W-1:2]])
                begin
                    $error("prdata mismatch: expected %h, actual %h",
                           param_shadow[paddr[ADDR_W-1:2]], prdata);
                    errors++;
                end
            end
        end
    end

endmodule

// ===== sim/testbench.sv =====
// Top of the command frame responder testbench: clock, reset, frame stimulus and verdict.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import cfr_pkg::*;

    localparam int TX_HOLD_CYCLES = 250;
    localparam int SETTLE_CYCLES  = 4;
    localparam int END_CYCLES     = 20;

    logic              clk     = 1'b0;
    logic              rst_n   = 1'b0;
    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [ADDR_W-1:0] paddr   = '0;
    logic [DATA_W-1:0] pwdata  = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    int   mismatch_count;
    int   replies_pending;
    int   words_sent  = 0;
    bit   rx_idle_on  = 1'b1;
    bit   tx_idle_on  = 1'b1;
    bit   tx_hold_req = 1'b0;

    cfr_rx_if rx_ch();
    cfr_tx_if tx_ch();

    command_frame_responder DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .rx      (rx_ch),
        .tx      (tx_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    frame_reply_checker reply_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .rx              (rx_ch),
        .tx              (tx_ch),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .mismatch_count  (mismatch_count),
        .replies_pending (replies_pending)
    );

    always #1 clk = ~clk;

    initial
    begin
        #200us;
        $display("*** FAILED ***");
        $finish;
    end

    // Reply receiver: random stalls, plus one long hold-off on request.
    initial
    begin
        tx_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (!rst_n)
                tx_ch.ready <= 1'b0;
            else if (tx_hold_req)
            begin
                tx_hold_req = 1'b0;
                tx_ch.ready <= 1'b0;
                repeat (TX_HOLD_CYCLES - 1) @(posedge clk);
            end
            else
                tx_ch.ready <= !tx_idle_on || ($urandom_range(0, 99) >= 9);
        end
    end

    task automatic send_word(input logic [7:0] b, input logic l);
        if (rx_idle_on && $urandom_range(0, 99) < 9)
        begin
            rx_ch.valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(0, 99) < 30)
                @(posedge clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        rx_ch.rx_last <= l;
        do
            @(posedge clk);
        while (!rx_ch.ready);
        words_sent++;
    endtask

    task automatic send_frame(input int len, input logic [7:0] fn, input logic [15:0] id,
                              input logic [7:0] sa, input logic [7:0] sb, input bit hdr_ok);
        logic [7:0] b;
        for (int i = 0; i < len; i++)
        begin
            b = 8'($urandom);
            case (i)
                0:  if (hdr_ok) b = HDR_SYNC;
                1:  if (hdr_ok) b = HDR_ADDR;
                2:  b = fn;
                4:  b = id[7:0];
                5:  b = id[15:8];
                15: b = sa;
                16: b = sb;
                default: ;
            endcase
            send_word(b, i == len - 1);
        end
    endtask

    // Mostly well-formed frames long enough to reach the id, some also the status
    // words, some truncated, some long enough to saturate the position counter.
    task automatic send_random_frame();
        int          len;
        int          r;
        logic [7:0]  fn;
        logic [15:0] id;
        r = $urandom_range(0, 99);
        if (r < 10)
            len = $urandom_range(1, 6);
        else if (r < 93)
            len = $urandom_range(6, 24);
        else
            len = $urandom_range(60, 72);
        r = $urandom_range(0, 99);
        if (r < 40)
            fn = FN_PARAM_READ;
        else if (r < 75)
            fn = FN_ACK;
        else if (r < 85)
            fn = FN_PARAM_REPLY;
        else
            fn = 8'($urandom);
        r = $urandom_range(0, 99);
        if (r < 60)
            id = 16'($urandom_range(0, 5));
        else if (r < 70)
            id = 16'hFFFF;
        else if (r < 78)
            id = {8'($urandom), 8'($urandom_range(1, 4))};
        else
            id = 16'($urandom);
        send_frame(len, fn, id, 8'($urandom), 8'($urandom), $urandom_range(0, 99) >= 15);
    endtask

    task automatic wait_idle();
        rx_ch.valid <= 1'b0;
        @(posedge clk);
        while (replies_pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_access(input reg_idx_t idx, input bit wr, input param_word_t value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic read_back_params();
        apb_access(REG_PARAM_ONE, 1'b0, '0);
        apb_access(REG_PARAM_TWO, 1'b0, '0);
        apb_access(REG_PARAM_THREE, 1'b0, '0);
        apb_access(REG_PARAM_FOUR, 1'b0, '0);
    endtask

    task automatic write_params(input param_word_t p1, input param_word_t p2,
                                input param_word_t p3, input param_word_t p4);
        apb_access(REG_PARAM_ONE, 1'b1, p1);
        apb_access(REG_PARAM_TWO, 1'b1, p2);
        apb_access(REG_PARAM_THREE, 1'b1, p3);
        apb_access(REG_PARAM_FOUR, 1'b1, p4);
        read_back_params();
    endtask

    initial
    begin
        rx_ch.valid   = 1'b0;
        rx_ch.rx_byte = '0;
        rx_ch.rx_last = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        read_back_params();

        // Directed frames against the reset values: frames that stop before the
        // function code or the id, parameter id one and id 0xFFFF, and an acknowledge whose
        // status words never arrive.
        send_word(8'h00, 1'b1);
        send_frame(2, FN_PARAM_READ, ID_PARAM_ONE, 8'hFF, 8'hFF, 1'b1);
        send_frame(3, FN_PARAM_READ, ID_PARAM_ONE, 8'hFF, 8'hFF, 1'b1);
        send_frame(6, FN_PARAM_READ, ID_PARAM_ONE, 8'h00, 8'h00, 1'b1);
        send_frame(6, FN_PARAM_READ, 16'hFFFF, 8'h00, 8'h00, 1'b0);
        send_frame(5, FN_ACK, ID_PARAM_TWO, 8'hFF, 8'hFF, 1'b1);

        wait_idle();
        write_params(32'h0000_0000, 32'hFFFF_FFFF, $urandom, $urandom);
        send_frame(17, FN_ACK, 16'h0000, 8'hFF, 8'h00, 1'b1);
        send_frame(17, FN_ACK, 16'hFFFF, 8'h00, 8'hFF, 1'b1);
        send_frame(6, FN_PARAM_READ, ID_PARAM_FOUR, 8'h00, 8'h00, 1'b1);
        while (words_sent < 140)
            send_random_frame();

        // A long stretch with no idling on either side.
        wait_idle();
        write_params(32'hFFFF_FFFF, 32'h0000_0000, 32'h8000_0000, $urandom);
        rx_idle_on = 1'b0;
        tx_idle_on = 1'b0;
        send_frame(70, FN_ACK, 16'h0003, 8'($urandom), 8'($urandom), 1'b1);
        while (words_sent < 240)
            send_random_frame();

        // The receiver holds off while frames keep coming, so the block fills up.
        wait_idle();
        write_params($urandom, $urandom, $urandom, $urandom);
        rx_idle_on  = 1'b1;
        tx_idle_on  = 1'b1;
        tx_hold_req = 1'b1;
        while (words_sent < 370)
            send_random_frame();

        rx_ch.valid <= 1'b0;
        @(posedge clk);
        while (replies_pending != 0)
            @(posedge clk);
        repeat (END_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && replies_pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/cfr_pkg.sv
rtl/cfr_stream_if.sv
rtl/cfr_regs.sv
rtl/cfr_ctrl.sv
rtl/cfr_datapath.sv
rtl/command_frame_responder.sv
rtl/cfr_checker.sv
sim/frame_reply_checker.sv
sim/testbench.sv
